### src/bba_pkg.sv
// Shared types and constants of the bitmap block allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

  localparam int TOTAL_BLOCKS = 32768;
  localparam int WORD_BITS   = 32;
  localparam int MAP_WORDS   = TOTAL_BLOCKS / WORD_BITS;
  localparam int BLK_W       = $clog2(TOTAL_BLOCKS);      // block index inside the map
  localparam int WIDX_W      = $clog2(MAP_WORDS);         // word index inside the map
  localparam int BLOCK_SHIFT = 12;                        // 4096-byte blocks
  localparam int ABLK_W      = 32 - BLOCK_SHIFT;          // block index from a byte address
  localparam int LEN_W       = 16;
  localparam int CNT_W       = 16;

  localparam logic [CNT_W-1:0] MANAGED_RESET = 16'd32768;
  localparam logic [CNT_W-1:0] COUNT_RESET   = 16'd32768;
  localparam logic [31:0]      FULL_WORD     = 32'hFFFF_FFFF;

  // request codes on the input word
  localparam logic [1:0] REQ_ALLOC_ONE = 2'd0;
  localparam logic [1:0] REQ_ALLOC_RUN = 2'd1;
  localparam logic [1:0] REQ_FREE_RUN  = 2'd2;
  localparam logic [1:0] REQ_QUERY     = 2'd3;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_QUERY
  } op_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [31:0]      block_address;
    logic [LEN_W-1:0] run_length;
  } req_t;

  typedef struct packed {
    logic [31:0]      result_address;
    logic             status;
    logic             is_allocated;
    logic [CNT_W-1:0] used_blocks;
  } resp_t;

  typedef struct packed {
    op_t               op;
    logic [ABLK_W-1:0] blk;
    logic [LEN_W-1:0]  want;
  } cmd_t;

  // back part status seen by the front
  typedef struct packed {
    logic clearing;
    logic take;
  } back_stat_t;

endpackage
`default_nettype wire

### src/bba_front.sv
// Front part: accepts request words, classifies them and queues them.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bba_front
  import bba_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire req_t       in_word,
  input  wire back_stat_t bstat,
  output logic            cmd_valid,
  output cmd_t            cmd
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       cls;

  always_comb begin
    cls.blk  = in_word.block_address[31:BLOCK_SHIFT];
    cls.want = in_word.run_length;
    unique case (in_word.req_type)
      REQ_ALLOC_ONE: begin
        cls.op   = OP_ALLOC;
        cls.want = LEN_W'(1);
      end
      REQ_ALLOC_RUN: cls.op = OP_ALLOC;
      REQ_FREE_RUN:  cls.op = OP_FREE;
      default:       cls.op = OP_QUERY;
    endcase
  end

  assign in_stall  = (count == 2'd2) || bstat.clearing;
  assign push      = in_valid && !in_stall;
  assign pop       = bstat.take;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

### src/bba_back.sv
// Back part: bitmap memory, first-fit scan, range update sequencer and result register.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bba_back
  import bba_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  input  wire cmd_t             cmd,
  output back_stat_t            bstat,
  input  wire logic             cfg_write,
  input  wire logic [CNT_W-1:0] cfg_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output resp_t                 out_word
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ALLOC, S_FREE, S_QUERY, S_QCHK,
    S_SCAN_RD, S_SCAN, S_RMW_RD, S_RMW_WR, S_RESP
  } state_t;

  state_t            state;
  cmd_t              cur;
  logic [CNT_W-1:0]  managed;
  logic [CNT_W-1:0]  used_count;
  logic [WIDX_W:0]   widx;
  logic [1:0]        bsel;
  logic [LEN_W-1:0]  run;
  logic [BLK_W-1:0]  first;
  logic [BLK_W-1:0]  rng_b;
  logic [BLK_W:0]    rng_end;
  logic              set_bits;
  logic [31:0]       res_addr;
  logic              res_status;
  logic              res_alloc;

  logic [31:0]       mem [MAP_WORDS];
  logic [31:0]       rdata;
  logic [WIDX_W-1:0] mem_addr;
  logic              mem_re;
  logic              mem_we;
  logic [31:0]       mem_wdata;

  logic [WIDX_W:0]   words;
  logic              out_free;
  logic [LEN_W-1:0]  b_run;
  logic [BLK_W-1:0]  b_first;
  logic              b_found;
  logic [BLK_W-1:0]  pos;
  logic [7:0]        byte_bits;
  logic [4:0]        lo;
  logic [5:0]        hi;
  logic [BLK_W-1:0]  end_m1;
  logic              is_last;
  logic [31:0]       mask;
  logic [LEN_W:0]    add_sum;
  logic [ABLK_W:0]   free_end;

  assign words    = (managed[CNT_W-1:5] > (WIDX_W+1)'(MAP_WORDS))
                    ? (WIDX_W+1)'(MAP_WORDS) : managed[CNT_W-1:5];
  assign out_free = !out_valid || !out_stall;

  assign bstat.clearing = (state == S_CLEAR);
  assign bstat.take     = (state == S_IDLE) && cmd_valid;

  // one byte of the scanned word per cycle
  always_comb begin
    b_run     = run;
    b_first   = first;
    b_found   = 1'b0;
    pos       = '0;
    byte_bits = rdata[{bsel, 3'b000} +: 8];
    for (int k = 0; k < 8; k++) begin
      pos = {widx[WIDX_W-1:0], bsel, 3'(k)};
      if (!b_found) begin
        if (byte_bits[k]) begin
          b_run = '0;
        end else begin
          if (b_run == '0) b_first = pos;
          b_run = b_run + LEN_W'(1);
          if (b_run == cur.want) b_found = 1'b1;
        end
      end
    end
  end

  // mask of the range inside the current word
  always_comb begin
    end_m1  = rng_end[BLK_W-1:0] - BLK_W'(1);
    is_last = (widx[WIDX_W-1:0] == end_m1[BLK_W-1:5]);
    lo      = (widx[WIDX_W-1:0] == rng_b[BLK_W-1:5]) ? rng_b[4:0] : 5'd0;
    hi      = (rng_end[4:0] == 5'd0) ? 6'd32 : {1'b0, rng_end[4:0]};
    mask    = (FULL_WORD << lo) & (is_last ? ~(FULL_WORD << hi) : FULL_WORD);
  end

  assign add_sum  = {1'b0, used_count} + {1'b0, cur.want};
  assign free_end = {1'b0, cur.blk} + (ABLK_W+1)'(cur.want);

  always_comb begin
    mem_addr  = widx[WIDX_W-1:0];
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = set_bits ? (rdata | mask) : (rdata & ~mask);
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = FULL_WORD;
      end
      S_QUERY: begin
        mem_addr = cur.blk[BLK_W-1:5];
        mem_re   = 1'b1;
      end
      S_SCAN_RD: mem_re = (widx < words);
      S_RMW_RD:  mem_re = 1'b1;
      S_RMW_WR:  mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      widx       <= '0;
      managed    <= MANAGED_RESET;
      used_count <= COUNT_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) managed <= cfg_data;
      // S_RESP refills the output register itself
      if (out_valid && !out_stall && state != S_RESP) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (widx[WIDX_W-1:0] == WIDX_W'(MAP_WORDS - 1)) begin
            widx  <= '0;
            state <= S_IDLE;
          end else begin
            widx <= widx + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur        <= cmd;
            res_addr   <= '0;
            res_status <= 1'b0;
            res_alloc  <= 1'b0;
            unique case (cmd.op)
              OP_ALLOC: state <= S_ALLOC;
              OP_FREE:  state <= S_FREE;
              default:  state <= S_QUERY;
            endcase
          end
        end
        S_ALLOC: begin
          widx <= '0;
          run  <= '0;
          if (cur.want == '0 || used_count >= managed) begin
            res_addr   <= FULL_WORD;
            res_status <= 1'b1;
            state      <= S_RESP;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          bsel <= 2'd0;
          if (widx >= words) begin
            res_addr   <= FULL_WORD;
            res_status <= 1'b1;
            state      <= S_RESP;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rdata == FULL_WORD) begin
            run   <= '0;
            widx  <= widx + 1'b1;
            state <= S_SCAN_RD;
          end else if (b_found) begin
            rng_b      <= b_first;
            rng_end    <= (BLK_W+1)'({1'b0, b_first} + (LEN_W+1)'(cur.want));
            set_bits   <= 1'b1;
            widx       <= {1'b0, b_first[BLK_W-1:5]};
            res_addr   <= 32'({b_first, BLOCK_SHIFT'(0)});
            used_count <= add_sum[LEN_W] ? '1 : add_sum[CNT_W-1:0];
            state      <= S_RMW_RD;
          end else begin
            run   <= b_run;
            first <= b_first;
            bsel  <= bsel + 2'd1;
            if (bsel == 2'd3) begin
              widx  <= widx + 1'b1;
              state <= S_SCAN_RD;
            end
          end
        end
        S_FREE: begin
          used_count <= (used_count > cur.want) ? used_count - cur.want : '0;
          rng_b      <= cur.blk[BLK_W-1:0];
          rng_end    <= (free_end > (ABLK_W+1)'(TOTAL_BLOCKS))
                        ? (BLK_W+1)'(TOTAL_BLOCKS) : free_end[BLK_W:0];
          set_bits   <= 1'b0;
          widx       <= {1'b0, cur.blk[BLK_W-1:5]};
          if (cur.want == '0 || cur.blk >= ABLK_W'(TOTAL_BLOCKS)) begin
            state <= S_RESP;
          end else begin
            state <= S_RMW_RD;
          end
        end
        S_RMW_RD: state <= S_RMW_WR;
        S_RMW_WR: begin
          widx <= widx + 1'b1;
          if (is_last) state <= S_RESP;
          else         state <= S_RMW_RD;
        end
        S_QUERY: begin
          if (cur.blk >= ABLK_W'(TOTAL_BLOCKS)) begin
            res_alloc <= 1'b1;
            state     <= S_RESP;
          end else begin
            state <= S_QCHK;
          end
        end
        S_QCHK: begin
          res_alloc <= rdata[cur.blk[4:0]];
          state     <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_valid               <= 1'b1;
            out_word.result_address <= res_addr;
            out_word.status         <= res_status;
            out_word.is_allocated   <= res_alloc;
            out_word.used_blocks    <= used_count;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    bstat.take |-> cmd_valid) else $error("queue popped while empty");
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (widx < (WIDX_W+1)'(MAP_WORDS)))
    else $error("scan beyond bitmap");
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_RMW_WR))
    else $error("bitmap written outside clear or update");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && out_valid && out_stall) |=> (state == S_RESP))
    else $error("result dropped while output held");
`endif

endmodule
`default_nettype wire

### src/bitmap_block_allocator.sv
// Top level of the first-fit bitmap block allocator.
// Depends on bba_pkg, bba_front and bba_back.
`timescale 1ns / 1ps
`default_nettype none
// One used bit per 4096-byte block over 32768 blocks, held in a 1024 x 32
// single-port bitmap memory, plus a saturating used-block count. After reset
// the bitmap is swept to all ones (every block used), one word a cycle, so no
// request word is taken until the sweep ends; configuration writes are
// taken throughout. A two-entry queue decouples intake from execution, so up
// to two requests are taken while a result waits on the output register.
// Work per request, bound by the single bitmap port: allocation scans each
// word with one read and, unless the word is full, up to four byte
// steps (8 blocks a cycle) for each word scanned below managed_blocks, then
// a read and a write per word marked; free-run takes a read and a write per
// word touched; query reads one bitmap word; empty requests skip the bitmap.
module bitmap_block_allocator
  import bba_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire req_t             in_word,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output resp_t                 out_word,
  input  wire logic             cfg_write,
  input  wire logic [CNT_W-1:0] cfg_data
);

  logic       cmd_valid;
  cmd_t       cmd;
  back_stat_t bstat;

  // intake and classification
  bba_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .bstat     (bstat),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // bitmap, search and update sequencer
  bba_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .bstat     (bstat),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

### verif/bitmap_block_allocator_tb.sv
// Testbench for the first-fit bitmap block allocator.
// Depends on bba_pkg and bitmap_block_allocator; checks every result word
// against a local model of the bitmap and the used-block count.
`timescale 1ns / 1ps
module bitmap_block_allocator_tb;
  import bba_pkg::*;

  localparam int WATCHDOG_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  resp_t out_word;
  logic cfg_write = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;

  bitmap_block_allocator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // local copy of the allocator state
  logic [31:0] model_map [MAP_WORDS];
  int unsigned model_used;
  int unsigned model_managed;
  resp_t expected_words [$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit rx_stall_on = 1'b1;

  function automatic bit model_bit(int unsigned blk);
    if (blk >= TOTAL_BLOCKS) return 1'b1;
    return model_map[blk / WORD_BITS][blk % WORD_BITS];
  endfunction

  function automatic void model_set(int unsigned blk, bit v);
    if (blk < TOTAL_BLOCKS) model_map[blk / WORD_BITS][blk % WORD_BITS] = v;
  endfunction

  // first fit: a full word or any used bit breaks the run
  function automatic bit first_fit(int unsigned len, output int unsigned start);
    int unsigned words, run, first;
    words = model_managed / WORD_BITS;
    if (words > MAP_WORDS) words = MAP_WORDS;
    run = 0;
    first = 0;
    start = 0;
    if (len == 0) return 1'b0;
    for (int unsigned i = 0; i < words; i++) begin
      if (model_map[i] == FULL_WORD) begin
        run = 0;
        continue;
      end
      for (int unsigned j = 0; j < WORD_BITS; j++) begin
        if (model_map[i][j]) begin
          run = 0;
          continue;
        end
        if (run == 0) first = i * WORD_BITS + j;
        run++;
        if (run == len) begin
          start = first;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic resp_t allocator_outcome(req_t r);
    resp_t e;
    int unsigned blk, want, start;
    e = '0;
    blk = r.block_address >> BLOCK_SHIFT;
    case (r.req_type)
      REQ_ALLOC_ONE, REQ_ALLOC_RUN: begin
        want = (r.req_type == REQ_ALLOC_ONE) ? 1 : r.run_length;
        if (model_used < model_managed && first_fit(want, start)) begin
          for (int unsigned i = 0; i < want; i++) model_set(start + i, 1'b1);
          model_used = (model_used + want > 16'hFFFF) ? 16'hFFFF : model_used + want;
          e.result_address = 32'(start * (1 << BLOCK_SHIFT));
        end else begin
          e.result_address = FULL_WORD;
          e.status = 1'b1;
        end
      end
      REQ_FREE_RUN: begin
        for (int unsigned i = 0; i < r.run_length; i++) model_set(blk + i, 1'b0);
        model_used = (model_used > r.run_length) ? model_used - r.run_length : 0;
      end
      default: e.is_allocated = model_bit(blk);
    endcase
    e.used_blocks = model_used[CNT_W-1:0];
    return e;
  endfunction

  // one request word, with a random gap ahead of it; valid stays high on a zero gap
  task automatic send_request(logic [1:0] kind, logic [31:0] addr, logic [15:0] len);
    req_t r;
    int unsigned gap;
    r.req_type = kind;
    r.block_address = addr;
    r.run_length = len;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.push_back(allocator_outcome(r));
    @(negedge clk);
  endtask

  // write managed_blocks once the pipeline has drained
  task automatic set_managed(int unsigned value);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value[CNT_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    model_managed = value;
  endtask

  function automatic logic [31:0] blk_addr(int unsigned blk);
    return (blk << BLOCK_SHIFT) | $urandom_range(0, 4095);
  endfunction

  // result checker
  always @(posedge clk) begin
    resp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word %h", out_word);
        fail_count++;
      end else begin
        e = expected_words.pop_front();
        if (out_word.result_address !== e.result_address) begin
          $error("result_address: expected %h, got %h", e.result_address,
                 out_word.result_address);
          fail_count++;
        end
        if (out_word.status !== e.status) begin
          $error("status: expected %b, got %b", e.status, out_word.status);
          fail_count++;
        end
        if (out_word.is_allocated !== e.is_allocated) begin
          $error("is_allocated: expected %b, got %b", e.is_allocated,
                 out_word.is_allocated);
          fail_count++;
        end
        if (out_word.used_blocks !== e.used_blocks) begin
          $error("used_blocks: expected %0d, got %0d", e.used_blocks,
                 out_word.used_blocks);
          fail_count++;
        end
      end
    end
  end

  // receiver stall: at random, hold off for a random run of cycles while a word is shown
  initial begin
    int unsigned hold;
    forever begin
      @(negedge clk);
      if (rx_stall_on && out_valid && $urandom_range(0, 2) != 0) begin
        hold = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_boot_state;
    // everything used after reset: allocations fail, queries say used
    send_request(REQ_ALLOC_ONE, 32'h0, 16'h0);
    send_request(REQ_ALLOC_RUN, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(REQ_QUERY, 32'h0, 16'h0);
    send_request(REQ_QUERY, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_directed_ops;
    send_request(REQ_FREE_RUN, 32'h0, 16'd64);           // bring first two words in
    send_request(REQ_ALLOC_ONE, 32'h0, 16'h0);           // used < managed now
    send_request(REQ_ALLOC_RUN, 32'h0, 16'd0);           // zero length fails
    send_request(REQ_FREE_RUN, 32'h1000, 16'd0);         // zero length free
    send_request(REQ_ALLOC_RUN, 32'h0, 16'd40);          // crosses a word boundary
    send_request(REQ_QUERY, 32'h0000_1FFF, 16'h0);
    send_request(REQ_FREE_RUN, blk_addr(TOTAL_BLOCKS - 3), 16'd10);  // runs off the end
    send_request(REQ_QUERY, blk_addr(TOTAL_BLOCKS + 5), 16'h0);      // beyond the map
    send_request(REQ_FREE_RUN, 32'h0, 16'd64);           // clears already clear bits
    send_request(REQ_ALLOC_RUN, 32'h0, 16'd33);
    send_request(REQ_FREE_RUN, 32'h0, 16'hFFFF);         // count saturates at zero
    send_request(REQ_ALLOC_RUN, 32'h0, 16'hFFFF);        // too long to fit
  endtask

  task automatic test_register_extremes;
    set_managed(0);
    send_request(REQ_ALLOC_ONE, 32'h0, 16'h0);
    set_managed(31);                                     // no whole word searched
    send_request(REQ_ALLOC_ONE, 32'h0, 16'h0);
    set_managed(16'hFFFF);                               // larger than the map
    send_request(REQ_ALLOC_RUN, 32'h0, 16'd5);
    set_managed(64);
    send_request(REQ_ALLOC_RUN, 32'h0, 16'd70);
  endtask

  task automatic random_phase(int unsigned count, int unsigned span);
    int unsigned k, blk;
    logic [15:0] len;
    for (int unsigned n = 0; n < count; n++) begin
      k = $urandom_range(0, 9);
      blk = $urandom_range(0, span - 1);
      len = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 48));
      if (k < 2) send_request(REQ_ALLOC_ONE, $urandom, len);
      else if (k < 5) send_request(REQ_ALLOC_RUN, $urandom, len);
      else if (k < 8) send_request(REQ_FREE_RUN,
                                   ($urandom_range(0, 15) == 0) ? $urandom : blk_addr(blk),
                                   len);
      else send_request(REQ_QUERY,
                        ($urandom_range(0, 15) == 0) ? $urandom : blk_addr(blk), len);
    end
  endtask

  task automatic test_random_traffic;
    // small managed sizes keep searches short; one phase spans the lot
    set_managed(256);
    random_phase(160, 320);
    set_managed(1024);
    random_phase(160, 1100);
    rx_stall_on = 1'b0;
    random_phase(60, 1100);
    rx_stall_on = 1'b1;
    set_managed(32768);
    send_request(REQ_FREE_RUN, blk_addr(32000), 16'd768);
    random_phase(40, TOTAL_BLOCKS);
    set_managed(512);
    random_phase(140, 600);
  endtask

  initial begin
    model_used = COUNT_RESET;
    model_managed = MANAGED_RESET;
    for (int i = 0; i < MAP_WORDS; i++) model_map[i] = FULL_WORD;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_boot_state();
    test_directed_ops();
    test_register_extremes();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### bitmap_block_allocator.f
src/bba_pkg.sv
src/bba_front.sv
src/bba_back.sv
src/bitmap_block_allocator.sv
verif/bitmap_block_allocator_tb.sv
